/* rtl/core/lome_pkg.sv */
package lome_pkg;

    // Index and count width; covers any store depth up to 63 entries.
    localparam int IDX_W = 6;

    // Command codes.
    localparam logic [1:0] CMD_NEW    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;

    // Event kinds.
    localparam logic [1:0] EV_ACCEPTED  = 2'd0;
    localparam logic [1:0] EV_REJECTED  = 2'd1;
    localparam logic [1:0] EV_FILLED    = 2'd2;
    localparam logic [1:0] EV_CANCELLED = 2'd3;

    // Reject reasons.
    localparam logic [2:0] RSN_NONE      = 3'd0;
    localparam logic [2:0] RSN_BAD_CMD   = 3'd1;
    localparam logic [2:0] RSN_OFF_TICK  = 3'd2;
    localparam logic [2:0] RSN_BAD_QTY   = 3'd3;
    localparam logic [2:0] RSN_DUPLICATE = 3'd4;
    localparam logic [2:0] RSN_UNKNOWN   = 3'd5;
    localparam logic [2:0] RSN_BOOK_FULL = 3'd6;

    // Cell operation codes.
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SETREM = 2'd2;
    localparam logic [1:0] OP_INSERT = 2'd3;

    // One resting order.
    typedef struct packed {
        logic               valid;
        logic [31:0]        order_id;
        logic [15:0]        client;
        logic [31:0]        client_handle;
        logic signed [31:0] price;
        logic [30:0]        remaining;
        logic               side;
    } entry_t;

    // Update broadcast to every cell.
    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] idx;
        logic [30:0]      rem;
        entry_t           entry;
    } cell_op_t;

    // Search key broadcast to every cell.
    typedef struct packed {
        logic [15:0] client;
        logic [31:0] client_handle;
        logic        opp;
    } search_t;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic               key_hit;
        logic [IDX_W-1:0]   key_idx;
        logic [31:0]        key_oid;
        logic signed [31:0] key_price;
        logic [30:0]        key_rem;
        logic               key_side;
        logic               best_hit;
        logic [IDX_W-1:0]   best_idx;
        logic [31:0]        best_oid;
        logic signed [31:0] best_price;
        logic [30:0]        best_rem;
        logic [15:0]        best_client;
        logic [31:0]        best_clo;
    } token_t;

    // Status of the remainder unit.
    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

    // One result transaction.
    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        order_id;
        logic [31:0]        rest_id;
        logic [15:0]        client;
        logic [31:0]        client_handle;
        logic signed [31:0] price;
        logic signed [31:0] quantity;
        logic [15:0]        rest_client;
        logic [31:0]        rest_handle;
        logic               side;
        logic [2:0]         reason;
        logic               last;
    } event_t;

endpackage

/* rtl/core/lome_cell.sv */
module lome_cell
    import lome_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cell_op_t op,
    input  search_t  search,
    input  entry_t   next_entry,
    input  token_t   tok_in,
    output entry_t   entry,
    output token_t   tok_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    entry_t entry_reg;
    entry_t entry_next;
    token_t tok_reg;
    token_t tok_next;

    // Entry update: shift down on removal, overwrite on insert or partial fill.
    always_comb
    begin
        entry_next = entry_reg;
        case (op.kind)
            OP_REMOVE:
            begin
                if (MY_IDX >= op.idx)
                begin
                    entry_next = next_entry;
                end
            end
            OP_SETREM:
            begin
                if (MY_IDX == op.idx)
                begin
                    entry_next.remaining = op.rem;
                end
            end
            OP_INSERT:
            begin
                if (MY_IDX == op.idx)
                begin
                    entry_next = op.entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Entry register; reset clears the whole entry, valid bit included.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    // Token update: first key match wins, strictly better price wins.
    always_comb
    begin
        tok_next = tok_in;
        if (entry_reg.valid && !tok_in.key_hit &&
            entry_reg.client == search.client &&
            entry_reg.client_handle == search.client_handle)
        begin
            tok_next.key_hit   = 1'b1;
            tok_next.key_idx   = MY_IDX;
            tok_next.key_oid   = entry_reg.order_id;
            tok_next.key_price = entry_reg.price;
            tok_next.key_rem   = entry_reg.remaining;
            tok_next.key_side  = entry_reg.side;
        end
        if (entry_reg.valid && entry_reg.side == search.opp &&
            (!tok_in.best_hit ||
             (search.opp ? ($signed(entry_reg.price) < $signed(tok_in.best_price))
                         : ($signed(entry_reg.price) > $signed(tok_in.best_price)))))
        begin
            tok_next.best_hit    = 1'b1;
            tok_next.best_idx    = MY_IDX;
            tok_next.best_oid    = entry_reg.order_id;
            tok_next.best_price  = entry_reg.price;
            tok_next.best_rem    = entry_reg.remaining;
            tok_next.best_client = entry_reg.client;
            tok_next.best_clo    = entry_reg.client_handle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign entry   = entry_reg;
    assign tok_out = tok_reg;

endmodule

/* rtl/core/lome_rem.sv */
module lome_rem
    import lome_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [30:0] dividend,
    input  logic [15:0] divisor,
    output rem_status_t status
);

    logic        act_reg;
    logic        act_next;
    logic        done_reg;
    logic        done_next;
    logic [4:0]  cnt_reg;
    logic [4:0]  cnt_next;
    logic [15:0] r_reg;
    logic [15:0] r_next;
    logic [30:0] q_reg;
    logic [30:0] q_next;
    logic [15:0] d_reg;
    logic [15:0] d_next;
    logic [16:0] trial;

    // Restoring remainder, one dividend bit per cycle.
    always_comb
    begin
        act_next  = act_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        trial     = {r_reg, q_reg[30]};
        if (start)
        begin
            act_next = 1'b1;
            cnt_next = '0;
            r_next   = '0;
            q_next   = dividend;
            d_next   = divisor;
        end
        else if (act_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = 16'(trial - {1'b0, d_reg});
            end
            else
            begin
                r_next = trial[15:0];
            end
            q_next   = {q_reg[29:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd30)
            begin
                act_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            act_reg  <= act_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        q_reg <= q_next;
        d_reg <= d_next;
    end

    assign status.done = done_reg;
    assign status.zero = (r_reg == '0);

endmodule

/* rtl/core/limit_order_matching_engine_core.sv */
// Order book core: a chain of MAX_RESTING cells, each holding one resting order.
// One command at a time; in_stall is high until its last result is registered.
// Bad commands and new orders at a negative price are rejected without a tick check;
// other new orders pass the tick check, then chain passes until filled or none cross.
// A cancel makes one chain pass. Output stalls hold the sequencer.
// Reset empties the book at once and sets tick_size to 1; no clearing pass.
module limit_order_matching_engine_core
    import lome_pkg::*;
#(
    parameter int MAX_RESTING = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        tick_size,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [31:0]        sequence_req,
    input  logic [15:0]        client_id,
    input  logic [31:0]        client_order_id,
    input  logic               side,
    input  logic signed [31:0] price,
    input  logic signed [31:0] quantity,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         event_kind,
    output logic [31:0]        order_id,
    output logic [31:0]        resting_id,
    output logic [15:0]        echo_client,
    output logic [31:0]        echo_client_order,
    output logic signed [31:0] event_price,
    output logic signed [31:0] event_quantity,
    output logic [15:0]        resting_client,
    output logic [31:0]        resting_handle,
    output logic               event_side,
    output logic [2:0]         reject_reason,
    output logic               last_event
);

    localparam logic [IDX_W-1:0] DEPTH = IDX_W'(MAX_RESTING);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_TICK   = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_SEARCH = 3'd4;
    localparam logic [2:0] S_FINAL  = 3'd5;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [IDX_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   cnt_next;
    logic [IDX_W-1:0]   used_reg;
    logic [IDX_W-1:0]   used_next;
    logic [15:0]        tick_reg;
    logic [30:0]        rem_reg;
    logic [30:0]        rem_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    event_t             out_reg;
    event_t             out_next;

    logic [1:0]         cmd_reg;
    logic [31:0]        seq_reg;
    logic [15:0]        client_reg;
    logic [31:0]        clo_reg;
    logic               side_reg;
    logic signed [31:0] price_reg;
    logic signed [31:0] qty_reg;

    logic               in_take;
    logic               out_free;
    logic               rem_start;
    logic               crosses;
    logic [30:0]        fill;
    logic [15:0]        divisor;
    rem_status_t        rem_status;
    cell_op_t           op;
    search_t            search;
    entry_t             entries [MAX_RESTING];
    token_t             tokens  [MAX_RESTING+1];
    event_t             rej_ev;

    assign in_take   = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign divisor   = (tick_reg == '0) ? 16'd1 : tick_reg;

    assign search.client        = client_reg;
    assign search.client_handle = clo_reg;
    assign search.opp           = ~side_reg;

    // Chain of cells; a fresh empty token enters at the head every cycle.
    assign tokens[0] = '0;

    for (genvar i = 0; i < MAX_RESTING; i++)
    begin : g_cell
        entry_t nxt;
        if (i == MAX_RESTING - 1)
        begin : g_tail
            assign nxt = '0;
        end
        else
        begin : g_body
            assign nxt = entries[i+1];
        end
        lome_cell #(.IDX(i)) u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (op),
            .search     (search),
            .next_entry (nxt),
            .tok_in     (tokens[i]),
            .entry      (entries[i]),
            .tok_out    (tokens[i+1])
        );
    end

    // Tick grid check on the non-negative price.
    lome_rem u_rem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (price_reg[30:0]),
        .divisor  (divisor),
        .status   (rem_status)
    );

    // Fill size and crossing test against the best opposite order.
    assign fill = (rem_reg < tokens[MAX_RESTING].best_rem) ? rem_reg
                                                          : tokens[MAX_RESTING].best_rem;
    assign crosses = side_reg ?
        !($signed(price_reg) > $signed(tokens[MAX_RESTING].best_price)) :
        !($signed(price_reg) < $signed(tokens[MAX_RESTING].best_price));

    // Reject template echoing the command.
    always_comb
    begin
        rej_ev                    = '0;
        rej_ev.kind               = EV_REJECTED;
        rej_ev.order_id           = seq_reg;
        rej_ev.client             = client_reg;
        rej_ev.client_handle      = clo_reg;
        rej_ev.price              = price_reg;
        rej_ev.quantity           = qty_reg;
        rej_ev.side               = side_reg;
        rej_ev.last               = 1'b1;
    end

    // Command sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        used_next      = used_reg;
        rem_next       = rem_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        rem_start      = 1'b0;
        op             = '0;
        op.kind        = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                rem_next = qty_reg[30:0];
                cnt_next = '0;
                if (cmd_reg == CMD_CANCEL)
                begin
                    state_next = S_SEARCH;
                end
                else if (cmd_reg == CMD_NEW && !price_reg[31])
                begin
                    rem_start  = 1'b1;
                    state_next = S_TICK;
                end
                else if (out_free)
                begin
                    out_next        = rej_ev;
                    out_next.reason = (cmd_reg == CMD_NEW) ? RSN_OFF_TICK : RSN_BAD_CMD;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_TICK:
            begin
                if (rem_status.done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (rem_status.zero && !qty_reg[31] && qty_reg != '0)
                begin
                    cnt_next   = '0;
                    state_next = S_SEARCH;
                end
                else if (out_free)
                begin
                    out_next        = rej_ev;
                    out_next.reason = rem_status.zero ? RSN_BAD_QTY : RSN_OFF_TICK;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SEARCH:
            begin
                if (cnt_reg != DEPTH)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (out_free)
                begin
                    if (cmd_reg == CMD_CANCEL)
                    begin
                        state_next = S_IDLE;
                        out_valid_next = 1'b1;
                        if (tokens[MAX_RESTING].key_hit)
                        begin
                            out_next               = '0;
                            out_next.kind          = EV_CANCELLED;
                            out_next.order_id      = tokens[MAX_RESTING].key_oid;
                            out_next.client        = client_reg;
                            out_next.client_handle = clo_reg;
                            out_next.price         = tokens[MAX_RESTING].key_price;
                            out_next.quantity      = {1'b0, tokens[MAX_RESTING].key_rem};
                            out_next.side          = tokens[MAX_RESTING].key_side;
                            out_next.reason        = RSN_NONE;
                            out_next.last          = 1'b1;
                            op.kind                = OP_REMOVE;
                            op.idx                 = tokens[MAX_RESTING].key_idx;
                            used_next              = used_reg - 1'b1;
                        end
                        else
                        begin
                            out_next        = rej_ev;
                            out_next.reason = RSN_UNKNOWN;
                        end
                    end
                    else if (tokens[MAX_RESTING].key_hit)
                    begin
                        out_next        = rej_ev;
                        out_next.reason = RSN_DUPLICATE;
                        out_valid_next  = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else if (tokens[MAX_RESTING].best_hit && crosses)
                    begin
                        out_next               = '0;
                        out_next.kind          = EV_FILLED;
                        out_next.order_id      = seq_reg;
                        out_next.rest_id       = tokens[MAX_RESTING].best_oid;
                        out_next.client        = client_reg;
                        out_next.client_handle = clo_reg;
                        out_next.price         = tokens[MAX_RESTING].best_price;
                        out_next.quantity      = {1'b0, fill};
                        out_next.rest_client   = tokens[MAX_RESTING].best_client;
                        out_next.rest_handle   = tokens[MAX_RESTING].best_clo;
                        out_next.side          = side_reg;
                        out_next.reason        = RSN_NONE;
                        out_next.last          = 1'b0;
                        out_valid_next         = 1'b1;
                        op.idx                 = tokens[MAX_RESTING].best_idx;
                        if (tokens[MAX_RESTING].best_rem == fill)
                        begin
                            op.kind   = OP_REMOVE;
                            used_next = used_reg - 1'b1;
                        end
                        else
                        begin
                            op.kind = OP_SETREM;
                            op.rem  = tokens[MAX_RESTING].best_rem - fill;
                        end
                        rem_next = rem_reg - fill;
                        cnt_next = '0;
                        state_next = (rem_reg == fill) ? S_FINAL : S_SEARCH;
                    end
                    else
                    begin
                        state_next = S_FINAL;
                    end
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    out_next               = '0;
                    out_next.kind          = EV_ACCEPTED;
                    out_next.order_id      = seq_reg;
                    out_next.client        = client_reg;
                    out_next.client_handle = clo_reg;
                    out_next.price         = price_reg;
                    out_next.quantity      = {1'b0, rem_reg};
                    out_next.side          = side_reg;
                    out_next.reason        = RSN_NONE;
                    out_next.last          = 1'b1;
                    out_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                    if (rem_reg != '0)
                    begin
                        if (used_reg != DEPTH)
                        begin
                            op.kind                  = OP_INSERT;
                            op.idx                   = used_reg;
                            op.entry.valid           = 1'b1;
                            op.entry.order_id        = seq_reg;
                            op.entry.client          = client_reg;
                            op.entry.client_handle   = clo_reg;
                            op.entry.price           = price_reg;
                            op.entry.remaining       = rem_reg;
                            op.entry.side            = side_reg;
                            used_next                = used_reg + 1'b1;
                        end
                        else
                        begin
                            out_next.reason = RSN_BOOK_FULL;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            tick_reg      <= 16'd1;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                tick_reg <= tick_size;
            end
        end
    end

    // Command and event payload.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        out_reg <= out_next;
        if (in_take)
        begin
            cmd_reg    <= command;
            seq_reg    <= sequence_req;
            client_reg <= client_id;
            clo_reg    <= client_order_id;
            side_reg   <= side;
            price_reg  <= price;
            qty_reg    <= quantity;
        end
    end

    assign out_valid          = out_valid_reg;
    assign event_kind         = out_reg.kind;
    assign order_id           = out_reg.order_id;
    assign resting_id         = out_reg.rest_id;
    assign echo_client        = out_reg.client;
    assign echo_client_order  = out_reg.client_handle;
    assign event_price        = out_reg.price;
    assign event_quantity     = out_reg.quantity;
    assign resting_client     = out_reg.rest_client;
    assign resting_handle     = out_reg.rest_handle;
    assign event_side         = out_reg.side;
    assign reject_reason      = out_reg.reason;
    assign last_event         = out_reg.last;

    // The book never holds more orders than it has cells.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= DEPTH)
        else $error("resting count beyond store depth");

    // An insert only happens with a free cell.
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        op.kind == OP_INSERT |-> used_reg < DEPTH)
        else $error("insert into a full book");

    // A removal only happens on a non-empty book.
    a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        op.kind == OP_REMOVE |-> used_reg != '0)
        else $error("removal from an empty book");

    // The chain is only read after a full pass since the last change.
    a_search_settled: assert property (@(posedge clk) disable iff (!rst_n)
        (op.kind == OP_REMOVE || op.kind == OP_SETREM) |-> cnt_reg == DEPTH)
        else $error("book changed before the search settled");

endmodule
